[rtl/asu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, codes and types of the active-set coefficient update block.
// Used by asu_front, asu_back and active_set_coefficient_update.
package asu_pkg;

    localparam int MAX_ACTIVE  = 256;
    localparam int INDEX_BITS  = 16;
    localparam int COEF_BITS   = 32;
    localparam int POS_BITS    = 9;
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_BITS  = $clog2(MAX_ACTIVE);
    localparam int CNT_BITS   = $clog2(MAX_ACTIVE + 2);
    localparam int NORM_BITS  = COEF_BITS + 7;
    localparam int PROD_BITS  = 2 * COEF_BITS;
    localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS;
    localparam int ENTRY_BITS = INDEX_BITS + COEF_BITS;

    localparam int IN_STEP_LSB   = 0;
    localparam int IN_ELEM_LSB   = COEF_BITS;
    localparam int IN_VAR_LSB    = 2 * COEF_BITS;
    localparam int IN_DROP_LSB   = IN_VAR_LSB + INDEX_BITS;
    localparam int IN_FIELD_BITS = IN_DROP_LSB + POS_BITS;
    localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_BITS = OP_BITS;

    localparam int OUT_FIELD_BITS = POS_BITS + INDEX_BITS + COEF_BITS + NORM_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = STATUS_BITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OPTR_BITS   = $clog2(OUT_DEPTH);
    localparam int OCNT_BITS   = $clog2(OUT_DEPTH + 1);

    localparam logic [OP_BITS-1:0] OP_LOAD     = OP_BITS'(0);
    localparam logic [OP_BITS-1:0] OP_STEP     = OP_BITS'(1);
    localparam logic [OP_BITS-1:0] OP_ADD      = OP_BITS'(2);
    localparam logic [OP_BITS-1:0] OP_DROP     = OP_BITS'(3);
    localparam logic [OP_BITS-1:0] OP_ADD_DROP = OP_BITS'(4);

    localparam logic [STATUS_BITS-1:0] ST_OK   = STATUS_BITS'(0);
    localparam logic [STATUS_BITS-1:0] ST_SAT  = STATUS_BITS'(1);
    localparam logic [STATUS_BITS-1:0] ST_FULL = STATUS_BITS'(2);

    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_ACTIVE);
    localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [NORM_BITS-1:0] NORM_MAX = {NORM_BITS{1'b1}};

    typedef enum logic [2:0] {
        K_NONE,
        K_FULL,
        K_LOAD,
        K_APPEND,
        K_UPDATE,
        K_DROP
    } t_kind;

    typedef struct packed {
        logic                        is_load;
        logic                        is_append;
        logic                        is_element;
        logic                        drop_hit;
        logic                        append_at_count;
        logic                        last_drop;
        logic                        first;
        logic                        last;
        logic [CNT_BITS-1:0]         rpos;
        logic                        neg;
        logic [COEF_BITS-1:0]        mag_step;
        logic [COEF_BITS-1:0]        mag_elem;
        logic signed [COEF_BITS-1:0] elem;
        logic [INDEX_BITS-1:0]       var_idx;
    } t_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0]       var_idx;
        logic signed [COEF_BITS-1:0] coef;
    } t_entry;

    typedef struct packed {
        logic [POS_BITS-1:0]         pos;
        logic [INDEX_BITS-1:0]       var_idx;
        logic signed [COEF_BITS-1:0] coef;
        logic                        dropped;
        logic [NORM_BITS-1:0]        norm;
        logic [STATUS_BITS-1:0]      status;
        logic                        last;
    } t_result;

endpackage
`default_nettype wire

[rtl/asu_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module asu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/asu_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts input transfers, tracks the item number within a call,
// classifies each item and queues it for the back end. Depends on asu_pkg.
module asu_front
    import asu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // step_size, element_value, var_index, drop_position, zero fill
    input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,
    input  logic                     s_axis_tlast,
    // operation
    input  logic [IN_TUSER_BITS-1:0] s_axis_tuser,
    output logic                     o_valid,
    output t_item                    o_item,
    input  logic                     i_pop
);

    logic [OP_BITS-1:0]          op;
    logic signed [COEF_BITS-1:0] step;
    logic signed [COEF_BITS-1:0] elem;
    logic [POS_BITS-1:0]         drop_pos;
    logic                        accept;
    logic                        update_op;
    logic                        drop_op;
    t_item                       item;

    logic [CNT_BITS-1:0]  r_rpos;
    logic [CNT_BITS-1:0]  n_rpos;
    t_item                r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_q_wr;
    logic [QPTR_BITS-1:0] r_q_rd;
    logic [QCNT_BITS-1:0] r_q_count;
    logic [QCNT_BITS-1:0] n_q_count;

    assign op       = s_axis_tuser[OP_BITS-1:0];
    assign step     = s_axis_tdata[IN_STEP_LSB +: COEF_BITS];
    assign elem     = s_axis_tdata[IN_ELEM_LSB +: COEF_BITS];
    assign drop_pos = s_axis_tdata[IN_DROP_LSB +: POS_BITS];

    assign s_axis_tready = r_q_count < QCNT_BITS'(QUEUE_DEPTH);
    assign accept        = s_axis_tvalid & s_axis_tready;

    assign update_op = (op == OP_STEP) || (op == OP_ADD) || (op == OP_DROP) ||
                       (op == OP_ADD_DROP);
    assign drop_op   = (op == OP_DROP) || (op == OP_ADD_DROP);

    always_comb begin
        item.is_load         = op == OP_LOAD;
        item.is_append       = s_axis_tlast && ((op == OP_ADD) || (op == OP_ADD_DROP));
        item.is_element      = update_op && !item.is_append;
        item.drop_hit        = drop_op && ((32'(r_rpos) + 32'd1) == 32'(drop_pos));
        item.append_at_count = op == OP_ADD;
        item.last_drop       = s_axis_tlast && (op == OP_DROP);
        item.first           = r_rpos == '0;
        item.last            = s_axis_tlast;
        item.rpos            = r_rpos;
        item.neg             = step[COEF_BITS-1] ^ elem[COEF_BITS-1];
        item.mag_step        = step[COEF_BITS-1] ? (~step + COEF_BITS'(1)) : step;
        item.mag_elem        = elem[COEF_BITS-1] ? (~elem + COEF_BITS'(1)) : elem;
        item.elem            = elem;
        item.var_idx         = s_axis_tdata[IN_VAR_LSB +: INDEX_BITS];
    end

    always_comb begin
        n_rpos = r_rpos;
        if (accept) begin
            if (s_axis_tlast) begin
                n_rpos = '0;
            end else if (r_rpos < CNT_BITS'(MAX_ACTIVE + 1)) begin
                n_rpos = r_rpos + CNT_BITS'(1);
            end
        end
    end

    always_comb begin
        unique case ({accept, i_pop})
            2'b10:   n_q_count = r_q_count + QCNT_BITS'(1);
            2'b01:   n_q_count = r_q_count - QCNT_BITS'(1);
            default: n_q_count = r_q_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpos    <= '0;
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
        end else begin
            r_rpos    <= n_rpos;
            r_q_count <= n_q_count;
            if (accept) begin
                r_q_wr <= r_q_wr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_q_rd <= r_q_rd + QPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_q_wr] <= item;
        end
    end

    assign o_valid = r_q_count != '0;
    assign o_item  = r_q[r_q_rd];

endmodule
`default_nettype wire

[rtl/asu_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back end: store control, store RAM, multiply/round/accumulate pipeline,
// L1 norm and the output buffer. Depends on asu_pkg and asu_ram.
module asu_back
    import asu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // entry_position, entry_var, entry_coef, l1_norm
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    // entry_dropped, status
    output logic [OUT_TUSER_BITS-1:0] m_axis_tuser
);

    typedef struct packed {
        t_kind                       kind;
        logic [ADDR_BITS-1:0]        raddr;
        logic [ADDR_BITS-1:0]        waddr;
        logic [POS_BITS-1:0]         pos;
        logic                        first;
        logic                        last;
        logic                        neg;
        logic signed [COEF_BITS-1:0] elem;
        logic [INDEX_BITS-1:0]       var_idx;
        logic [PROD_BITS-1:0]        prod;
    } t_s1;

    typedef struct packed {
        t_kind                       kind;
        logic [ADDR_BITS-1:0]        waddr;
        logic [POS_BITS-1:0]         pos;
        logic                        first;
        logic                        last;
        logic signed [COEF_BITS-1:0] elem;
        logic [INDEX_BITS-1:0]       var_idx;
        logic signed [COEF_BITS-1:0] prod;
        logic                        prod_sat;
        t_entry                      stored;
    } t_s2;

    typedef struct packed {
        t_kind                       kind;
        logic [POS_BITS-1:0]         pos;
        logic [INDEX_BITS-1:0]       var_idx;
        logic signed [COEF_BITS-1:0] coef;
        logic                        sat;
        logic                        first;
        logic                        last;
    } t_s3;

    // store control
    logic [CNT_BITS-1:0]   r_active;
    logic [CNT_BITS-1:0]   r_wpos;
    logic [CNT_BITS-1:0]   n_active;
    logic [CNT_BITS-1:0]   n_wpos;
    logic [CNT_BITS-1:0]   dst;
    t_kind                 kind;
    logic [ADDR_BITS-1:0]  waddr;
    logic [POS_BITS-1:0]   pos;
    logic [OCNT_BITS:0]    in_flight;
    t_s1                   n_s1;

    // pipeline
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    t_s1                   r_s1;
    t_s2                   r_s2;
    t_s3                   r_s3;
    t_s2                   n_s2;
    t_s3                   n_s3;
    logic                  r_fw_we;
    logic [ADDR_BITS-1:0]  r_fw_addr;
    t_entry                r_fw_entry;
    t_entry                ram_rdata;

    logic [PROD_BITS-1:0]        rounded;
    logic [QUOT_BITS-1:0]        quot;
    logic [QUOT_BITS-1:0]        limit;
    logic [COEF_BITS-1:0]        quot_sat;

    logic                        s2_we;
    logic [COEF_BITS:0]          sum;
    logic signed [COEF_BITS-1:0] sum_sat;
    logic                        add_sat;
    t_entry                      s2_wentry;

    logic [COEF_BITS-1:0]  coef_mag;
    logic [NORM_BITS-1:0]  norm_base;
    logic [NORM_BITS:0]    norm_sum;
    logic [NORM_BITS-1:0]  norm_next;
    logic                  norm_sat;
    logic                  adds_norm;
    t_result               result;

    // output buffer
    logic [NORM_BITS-1:0]  r_norm;
    t_result               r_out [OUT_DEPTH];
    logic [OPTR_BITS-1:0]  r_out_wr;
    logic [OPTR_BITS-1:0]  r_out_rd;
    logic [OCNT_BITS-1:0]  r_out_count;
    logic [OCNT_BITS-1:0]  n_out_count;
    logic                  out_pop;
    t_result               out_head;

    // ------------------------------------------------------------------
    // Store control: one item per cycle while the output credit allows, counters updated in order.
    // ------------------------------------------------------------------
    assign in_flight = (OCNT_BITS+1)'(r_out_count) + (OCNT_BITS+1)'(r_v1) +
                       (OCNT_BITS+1)'(r_v2) + (OCNT_BITS+1)'(r_v3);
    assign o_pop     = i_valid && (in_flight < (OCNT_BITS+1)'(OUT_DEPTH));

    always_comb begin
        dst      = i_item.append_at_count ? r_active : r_wpos;
        kind     = K_NONE;
        waddr    = '0;
        pos      = '0;
        n_active = r_active;
        n_wpos   = r_wpos;
        if (i_item.is_load) begin
            if (i_item.rpos < MAX_CNT) begin
                kind     = K_LOAD;
                waddr    = i_item.rpos[ADDR_BITS-1:0];
                n_active = i_item.rpos + CNT_BITS'(1);
                n_wpos   = i_item.rpos + CNT_BITS'(1);
                pos      = POS_BITS'(i_item.rpos + CNT_BITS'(1));
            end else begin
                kind = K_FULL;
            end
        end else if (i_item.is_append) begin
            if (dst < MAX_CNT) begin
                kind     = K_APPEND;
                waddr    = dst[ADDR_BITS-1:0];
                n_active = dst + CNT_BITS'(1);
                pos      = POS_BITS'(dst + CNT_BITS'(1));
            end else begin
                kind = K_FULL;
                if (!i_item.append_at_count) begin
                    n_active = dst;
                end
            end
        end else if (i_item.is_element && (i_item.rpos < r_active) &&
                     (i_item.rpos < MAX_CNT)) begin
            if (i_item.drop_hit) begin
                kind = K_DROP;
            end else if (r_wpos < MAX_CNT) begin
                kind   = K_UPDATE;
                waddr  = r_wpos[ADDR_BITS-1:0];
                n_wpos = r_wpos + CNT_BITS'(1);
                pos    = POS_BITS'(r_wpos + CNT_BITS'(1));
            end else begin
                kind = K_FULL;
            end
        end
        if (i_item.last_drop) begin
            n_active = n_wpos;
        end
        if (i_item.last) begin
            n_wpos = '0;
        end
    end

    always_comb begin
        n_s1.kind    = kind;
        n_s1.raddr   = i_item.rpos[ADDR_BITS-1:0];
        n_s1.waddr   = waddr;
        n_s1.pos     = pos;
        n_s1.first   = i_item.first;
        n_s1.last    = i_item.last;
        n_s1.neg     = i_item.neg;
        n_s1.elem    = i_item.elem;
        n_s1.var_idx = i_item.var_idx;
        n_s1.prod    = PROD_BITS'(i_item.mag_step) * PROD_BITS'(i_item.mag_elem);
    end

    asu_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ACTIVE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s2_we),
        .i_waddr (r_s2.waddr),
        .i_wdata (s2_wentry),
        .i_raddr (n_s1.raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: round and saturate the product, forward pending writes.
    // ------------------------------------------------------------------
    always_comb begin
        rounded  = r_s1.prod + (PROD_BITS'(1) << (FRAC_BITS - 1));
        quot     = rounded[PROD_BITS-1:FRAC_BITS];
        limit    = (QUOT_BITS'(1) << (COEF_BITS - 1)) - QUOT_BITS'(!r_s1.neg);
        quot_sat = (quot > limit) ? limit[COEF_BITS-1:0] : quot[COEF_BITS-1:0];

        n_s2.kind     = r_s1.kind;
        n_s2.waddr    = r_s1.waddr;
        n_s2.pos      = r_s1.pos;
        n_s2.first    = r_s1.first;
        n_s2.last     = r_s1.last;
        n_s2.elem     = r_s1.elem;
        n_s2.var_idx  = r_s1.var_idx;
        n_s2.prod_sat = quot > limit;
        n_s2.prod     = r_s1.neg ? (~quot_sat + COEF_BITS'(1)) : quot_sat;
        if (s2_we && (r_s2.waddr == r_s1.raddr)) begin
            n_s2.stored = s2_wentry;
        end else if (r_fw_we && (r_fw_addr == r_s1.raddr)) begin
            n_s2.stored = r_fw_entry;
        end else begin
            n_s2.stored = ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: saturating accumulate and store write.
    // ------------------------------------------------------------------
    always_comb begin
        sum     = {r_s2.stored.coef[COEF_BITS-1], r_s2.stored.coef} +
                  {r_s2.prod[COEF_BITS-1], r_s2.prod};
        add_sat = sum[COEF_BITS] != sum[COEF_BITS-1];
        sum_sat = add_sat ? (sum[COEF_BITS] ? COEF_MIN : COEF_MAX) : sum[COEF_BITS-1:0];
        s2_we   = r_v2 && ((r_s2.kind == K_LOAD) || (r_s2.kind == K_APPEND) ||
                           (r_s2.kind == K_UPDATE));

        s2_wentry.var_idx = r_s2.var_idx;
        s2_wentry.coef    = r_s2.elem;
        n_s3.var_idx      = '0;
        n_s3.coef         = '0;
        n_s3.sat          = 1'b0;
        unique case (r_s2.kind)
            K_LOAD: begin
                n_s3.var_idx = r_s2.var_idx;
                n_s3.coef    = r_s2.elem;
            end
            K_APPEND: begin
                s2_wentry.coef = r_s2.prod;
                n_s3.var_idx   = r_s2.var_idx;
                n_s3.coef      = r_s2.prod;
                n_s3.sat       = r_s2.prod_sat;
            end
            K_UPDATE: begin
                s2_wentry.var_idx = r_s2.stored.var_idx;
                s2_wentry.coef    = sum_sat;
                n_s3.var_idx      = r_s2.stored.var_idx;
                n_s3.coef         = sum_sat;
                n_s3.sat          = r_s2.prod_sat | add_sat;
            end
            K_DROP: begin
                n_s3.var_idx = r_s2.stored.var_idx;
                n_s3.coef    = r_s2.stored.coef;
            end
            default: begin
                n_s3.var_idx = '0;
            end
        endcase
        n_s3.kind  = r_s2.kind;
        n_s3.pos   = r_s2.pos;
        n_s3.first = r_s2.first;
        n_s3.last  = r_s2.last;
    end

    // ------------------------------------------------------------------
    // Stage 3: running L1 norm and status.
    // ------------------------------------------------------------------
    always_comb begin
        adds_norm = (r_s3.kind == K_LOAD) || (r_s3.kind == K_APPEND) ||
                    (r_s3.kind == K_UPDATE);
        coef_mag  = r_s3.coef[COEF_BITS-1] ? (~r_s3.coef + COEF_BITS'(1)) : r_s3.coef;
        norm_base = r_s3.first ? '0 : r_norm;
        norm_sum  = (NORM_BITS+1)'(norm_base) +
                    (adds_norm ? (NORM_BITS+1)'(coef_mag) : '0);
        norm_sat  = norm_sum[NORM_BITS];
        norm_next = norm_sat ? NORM_MAX : norm_sum[NORM_BITS-1:0];

        result.pos     = r_s3.pos;
        result.var_idx = r_s3.var_idx;
        result.coef    = r_s3.coef;
        result.dropped = r_s3.kind == K_DROP;
        result.norm    = norm_next;
        result.last    = r_s3.last;
        if (r_s3.kind == K_FULL) begin
            result.status = ST_FULL;
        end else if (r_s3.sat || norm_sat) begin
            result.status = ST_SAT;
        end else begin
            result.status = ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: credit above keeps it from overflowing.
    // ------------------------------------------------------------------
    assign out_pop  = m_axis_tvalid && m_axis_tready;
    assign out_head = r_out[r_out_rd];

    always_comb begin
        unique case ({r_v3, out_pop})
            2'b10:   n_out_count = r_out_count + OCNT_BITS'(1);
            2'b01:   n_out_count = r_out_count - OCNT_BITS'(1);
            default: n_out_count = r_out_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_wpos      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_fw_we     <= 1'b0;
            r_norm      <= '0;
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (o_pop) begin
                r_active <= n_active;
                r_wpos   <= n_wpos;
            end
            r_v1        <= o_pop;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_fw_we     <= s2_we;
            r_out_count <= n_out_count;
            if (r_v3) begin
                r_norm   <= norm_next;
                r_out_wr <= r_out_wr + OPTR_BITS'(1);
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + OPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_s3       <= n_s3;
        r_fw_addr  <= r_s2.waddr;
        r_fw_entry <= s2_wentry;
        if (r_v3) begin
            r_out[r_out_wr] <= result;
        end
    end

    assign m_axis_tvalid = r_out_count != '0;
    assign m_axis_tdata  = OUT_TDATA_BITS'({out_head.norm, out_head.coef,
                                            out_head.var_idx, out_head.pos});
    assign m_axis_tlast  = out_head.last;
    assign m_axis_tuser  = {out_head.status, out_head.dropped};

`ifndef SYNTHESIS
    a_wpos_within_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= r_active)
        else $error("compaction pointer passed the active count");
    a_active_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= MAX_CNT)
        else $error("active count beyond store depth");
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((r_out_count < OCNT_BITS'(OUT_DEPTH)) || out_pop))
        else $error("result pushed into a full output buffer");
    a_call_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_wpos == '0))
        else $error("compaction pointer not rewound at end of call");
`endif

endmodule
`default_nettype wire

[rtl/active_set_coefficient_update.sv]
`timescale 1ns / 1ps
`default_nettype none
// Active-set coefficient update for a least-angle regression path. Takes one
// item per clock cycle while the output side accepts results; each item passes
// the input queue, the back-end stages and the output buffer, all registered,
// before its result is presented. The pace is set by the store RAM, which
// serves one read and one write per item. A 4-entry input queue and an
// 8-entry output buffer let either side stall alone. The store holds no reset
// contents and needs no clearing pass: entries are defined once a load or
// append call has written them. Depends on asu_pkg, asu_front and asu_back.
module active_set_coefficient_update
    import asu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // step_size, element_value, var_index, drop_position, zero fill
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // last_item
    input  logic                      s_axis_tlast,
    // operation
    input  logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // entry_position, entry_var, entry_coef, l1_norm
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // last_result
    output logic                      m_axis_tlast,
    // entry_dropped, status
    output logic [OUT_TUSER_BITS-1:0] m_axis_tuser
);

    logic  item_valid;
    logic  item_pop;
    t_item item;

    asu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (item_valid),
        .o_item        (item),
        .i_pop         (item_pop)
    );

    asu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (item_valid),
        .i_item        (item),
        .o_pop         (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for active_set_coefficient_update: streams load, step, add, drop
// and add-with-drop calls and checks every result against an in-bench store model.
// Depends on asu_pkg and the active_set_coefficient_update RTL.
module tb;
    import asu_pkg::*;

    localparam int PLAN         = 0;
    localparam int TRACK        = 1;
    localparam int ITEM_TARGET  = 1800;
    localparam int SYNC_EVERY   = 300;
    localparam int RX_HOLD_AT   = 400;
    localparam int RX_HOLD_LEN  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic                  hold;
        logic [OP_BITS-1:0]    op;
        logic [COEF_BITS-1:0]  gamma;
        logic [COEF_BITS-1:0]  elem;
        logic [INDEX_BITS-1:0] vidx;
        logic [POS_BITS-1:0]   drop_pos;
        logic                  last;
    } t_coef_item;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      s_axis_tlast  = 1'b0;
    logic [IN_TUSER_BITS-1:0]  s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tlast;
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;

    active_set_coefficient_update u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // two copies of the store: one steers stimulus, one predicts accepted transfers
    logic signed [COEF_BITS-1:0] st_coef    [2][MAX_ACTIVE];
    logic [INDEX_BITS-1:0]       st_var     [2][MAX_ACTIVE];
    bit                          st_written [2][MAX_ACTIVE];
    int                          st_count   [2];
    int                          st_rd      [2];
    int                          st_wr      [2];
    longint                      st_norm    [2];

    t_coef_item call_items[$];
    t_result    expected_entries[$];

    int  items_planned = 0;
    int  results_seen  = 0;
    int  fail_count    = 0;
    int  idle_cycles   = 0;
    int  tx_gap        = 0;
    int  tx_quiet      = 0;
    int  rx_gap        = 0;
    int  rx_quiet      = 0;
    int  rx_hold_left  = 0;
    bit  rx_hold_done  = 1'b0;
    bit  in_taken      = 1'b0;
    t_coef_item taken_item;
    t_result    want_entry;
    t_result    got_entry;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint q_mul(input longint a, input longint b, inout bit sat);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned q;
        longint unsigned lim;
        bit              neg;
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        q   = (ma * mb + 64'h8000) >> FRAC_BITS;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_sum(input longint a, input longint b, inout bit sat);
        longint s;
        s = a + b;
        if (s > 64'sh7fff_ffff) begin
            sat = 1'b1;
            return 64'sh7fff_ffff;
        end
        if (s < -64'sh8000_0000) begin
            sat = 1'b1;
            return -64'sh8000_0000;
        end
        return s;
    endfunction

    function automatic void norm_add(input int m, input longint c, inout bit sat);
        st_norm[m] += (c < 0) ? -c : c;
        if (st_norm[m] > longint'(NORM_MAX)) begin
            st_norm[m] = longint'(NORM_MAX);
            sat        = 1'b1;
        end
    endfunction

    function automatic void put_entry(input int m, input int at, input longint c,
                                      input logic [INDEX_BITS-1:0] vidx);
        st_coef[m][at]    = COEF_BITS'(c);
        st_var[m][at]     = vidx;
        st_written[m][at] = 1'b1;
    endfunction

    function automatic t_result apply_coef_item(input int m, input t_coef_item it);
        int      r;
        int      dst;
        bit      sat;
        bit      full;
        bit      dropping;
        longint  g;
        longint  w;
        longint  c;
        t_result res;
        r        = st_rd[m];
        sat      = 1'b0;
        full     = 1'b0;
        g        = longint'($signed(it.gamma));
        w        = longint'($signed(it.elem));
        res      = '0;
        dropping = (it.op == OP_DROP) || (it.op == OP_ADD_DROP);
        if (r == 0) st_norm[m] = 0;
        if (it.op == OP_LOAD) begin
            if (r < MAX_ACTIVE) begin
                put_entry(m, r, w, it.vidx);
                st_count[m] = r + 1;
                st_wr[m]    = r + 1;
                res.pos     = POS_BITS'(r + 1);
                res.var_idx = it.vidx;
                res.coef    = it.elem;
                norm_add(m, w, sat);
            end else begin
                full = 1'b1;
            end
        end else if (it.op <= OP_ADD_DROP) begin
            if (it.last && (it.op == OP_ADD || it.op == OP_ADD_DROP)) begin
                dst = (it.op == OP_ADD) ? st_count[m] : st_wr[m];
                c   = q_mul(g, w, sat);
                if (dst < MAX_ACTIVE) begin
                    put_entry(m, dst, c, it.vidx);
                    st_count[m] = dst + 1;
                    res.pos     = POS_BITS'(dst + 1);
                    res.var_idx = it.vidx;
                    res.coef    = COEF_BITS'(c);
                    norm_add(m, c, sat);
                end else begin
                    full = 1'b1;
                    if (it.op == OP_ADD_DROP) st_count[m] = dst;
                end
            end else if (r < st_count[m] && r < MAX_ACTIVE) begin
                if (dropping && r + 1 == int'(it.drop_pos)) begin
                    res.dropped = 1'b1;
                    res.var_idx = st_var[m][r];
                    res.coef    = st_coef[m][r];
                end else begin
                    c   = q_mul(g, w, sat);
                    c   = sat_sum(longint'(st_coef[m][r]), c, sat);
                    dst = st_wr[m];
                    if (dst < MAX_ACTIVE) begin
                        put_entry(m, dst, c, st_var[m][r]);
                        st_wr[m]    = dst + 1;
                        res.pos     = POS_BITS'(dst + 1);
                        res.var_idx = st_var[m][dst];
                        res.coef    = COEF_BITS'(c);
                        norm_add(m, c, sat);
                    end else begin
                        full = 1'b1;
                    end
                end
            end
            if (it.last && it.op == OP_DROP) st_count[m] = st_wr[m];
        end
        if (it.last) begin
            st_rd[m] = 0;
            st_wr[m] = 0;
        end else if (r < MAX_ACTIVE + 1) begin
            st_rd[m] = r + 1;
        end
        res.norm   = NORM_BITS'(st_norm[m]);
        res.status = full ? ST_FULL : (sat ? ST_SAT : ST_OK);
        res.last   = it.last;
        return res;
    endfunction

    function automatic bit reads_unwritten(input int m, input t_coef_item it);
        int r;
        r = st_rd[m];
        if (it.op < OP_STEP || it.op > OP_ADD_DROP) return 1'b0;
        if (it.last && (it.op == OP_ADD || it.op == OP_ADD_DROP)) return 1'b0;
        return r < st_count[m] && r < MAX_ACTIVE && !st_written[m][r];
    endfunction

    function automatic logic [COEF_BITS-1:0] rand_q16();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return COEF_BITS'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        if (pick < 70) return $urandom;
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'hffff_ffff;
            5: return 32'h0001_0000;
            6: return 32'hffff_0000;
            default: return 32'h0000_8000;
        endcase
    endfunction

    function automatic int next_gap(inout int quiet);
        int pick;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0) begin
            quiet = $urandom_range(50, 200);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 16);
        return $urandom_range(30, 100);
    endfunction

    task automatic plan_item(input logic [OP_BITS-1:0] op, input logic [COEF_BITS-1:0] g,
                             input logic [COEF_BITS-1:0] w, input logic [INDEX_BITS-1:0] vidx,
                             input logic [POS_BITS-1:0] dp, input logic last);
        t_coef_item it;
        it.hold     = 1'b0;
        it.op       = op;
        it.gamma    = g;
        it.elem     = w;
        it.vidx     = vidx;
        it.drop_pos = dp;
        it.last     = last;
        if (reads_unwritten(PLAN, it)) it.op = OP_LOAD;
        void'(apply_coef_item(PLAN, it));
        call_items.push_back(it);
        items_planned++;
    endtask

    task automatic plan_call(input logic [OP_BITS-1:0] op, input int len,
                             input logic [COEF_BITS-1:0] g, input logic [POS_BITS-1:0] dp);
        for (int i = 0; i < len; i++) begin
            plan_item(op, g, rand_q16(), INDEX_BITS'($urandom), dp, i == len - 1);
        end
    endtask

    task automatic plan_sync();
        t_coef_item it;
        it      = '0;
        it.hold = 1'b1;
        call_items.push_back(it);
    endtask

    function automatic logic [POS_BITS-1:0] pick_drop(input int cnt);
        if ($urandom_range(0, 9) != 0) return POS_BITS'($urandom_range(1, cnt));
        if ($urandom_range(0, 1) == 0) return '0;
        return POS_BITS'($urandom_range(cnt + 1, 511));
    endfunction

    task automatic plan_directed();
        plan_item(OP_LOAD, 32'h0, 32'h7fff_ffff, 16'h0000, 9'd0, 1'b0);
        plan_item(OP_LOAD, 32'h0, 32'h8000_0000, 16'hffff, 9'd0, 1'b0);
        plan_item(OP_LOAD, 32'h0, 32'h0000_0000, 16'h1234, 9'd0, 1'b1);
        // saturate both ways, then a plain half step
        plan_item(OP_STEP, 32'h0001_0000, 32'h0000_0001, 16'h0, 9'd0, 1'b0);
        plan_item(OP_STEP, 32'h0001_0000, 32'hffff_ffff, 16'h0, 9'd0, 1'b0);
        plan_item(OP_STEP, 32'h0001_0000, 32'h0000_8000, 16'h0, 9'd0, 1'b1);
        // rounding ties both signs and one just below a tie, then an item past the store
        plan_item(OP_STEP, 32'h0000_0001, 32'h0000_8000, 16'h0, 9'd0, 1'b0);
        plan_item(OP_STEP, 32'h0000_0001, 32'hffff_8000, 16'h0, 9'd0, 1'b0);
        plan_item(OP_STEP, 32'h0000_0001, 32'h0000_7fff, 16'h0, 9'd0, 1'b0);
        plan_item(OP_STEP, 32'h0000_0001, 32'h7fff_ffff, 16'h0, 9'd0, 1'b1);
        plan_item(OP_ADD, 32'h7fff_ffff, 32'h0, 16'h0, 9'd0, 1'b0);
        plan_item(OP_ADD, 32'h7fff_ffff, 32'h0, 16'h0, 9'd0, 1'b0);
        plan_item(OP_ADD, 32'h7fff_ffff, 32'h0, 16'h0, 9'd0, 1'b0);
        plan_item(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 16'habcd, 9'd0, 1'b1);
        plan_call(OP_DROP, 4, 32'h0, 9'd2);
        plan_call(OP_DROP, 3, 32'h0, 9'd0);
        plan_call(OP_DROP, 1, 32'h0, 9'd0);
        plan_item(OP_ADD_DROP, 32'h0001_0000, 32'h0002_0000, 16'h5555, 9'd1, 1'b0);
        plan_item(OP_ADD_DROP, 32'h0001_0000, 32'h0002_0000, 16'haaaa, 9'd1, 1'b1);
        plan_item(OP_BITS'(5), 32'h0, 32'h0, 16'h0, 9'd0, 1'b1);
        plan_item(OP_BITS'(6), 32'h0, 32'h0, 16'h0, 9'd0, 1'b1);
        plan_item(OP_BITS'(7), 32'h0, 32'h0, 16'h0, 9'd0, 1'b1);
    endtask

    task automatic plan_full_store();
        for (int i = 0; i <= MAX_ACTIVE; i++) begin
            plan_item(OP_LOAD, rand_q16(), 32'h8000_0000, INDEX_BITS'($urandom), 9'd0,
                      i == MAX_ACTIVE);
        end
        plan_item(OP_ADD, 32'h0001_0000, 32'h0001_0000, 16'h7777, 9'd0, 1'b1);
        plan_call(OP_ADD_DROP, MAX_ACTIVE + 1, 32'h0, 9'd0);
        plan_call(OP_LOAD, 4, 32'h0, 9'd0);
    endtask

    task automatic plan_random();
        int pick;
        int cnt;
        int len;
        int next_sync;
        next_sync = items_planned + SYNC_EVERY;
        while (items_planned < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            cnt  = st_count[PLAN];
            if (cnt == 0 || cnt > 40 || pick < 12) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                plan_call(OP_LOAD, len, 32'h0, POS_BITS'($urandom));
            end else if (pick < 35) begin
                plan_call(OP_STEP, cnt, rand_q16(), POS_BITS'($urandom));
            end else if (pick < 50) begin
                plan_call(OP_ADD, cnt + 1, rand_q16(), POS_BITS'($urandom));
            end else if (pick < 65) begin
                plan_call(OP_DROP, cnt, rand_q16(), pick_drop(cnt));
            end else if (pick < 80) begin
                plan_call(OP_ADD_DROP, cnt + 1, rand_q16(), pick_drop(cnt));
            end else if (pick < 90) begin
                plan_call(OP_BITS'($urandom_range(1, 4)), $urandom_range(1, cnt + 3),
                          rand_q16(), POS_BITS'($urandom_range(0, cnt + 2)));
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    plan_item(OP_BITS'($urandom_range(0, 7)), rand_q16(), rand_q16(),
                              INDEX_BITS'($urandom), POS_BITS'($urandom_range(0, 511)),
                              i == len - 1);
                end
            end
            if (items_planned >= next_sync) begin
                plan_sync();
                next_sync = items_planned + SYNC_EVERY;
            end
        end
    endtask

    // input side: hold, gap or present the head of the queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            s_axis_tvalid <= 1'b1;
        end else begin
            in_taken = 1'b0;
            if (tx_gap > 0 && rx_hold_left == 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (call_items.size() != 0 && call_items[0].hold) begin
                s_axis_tvalid <= 1'b0;
                if (expected_entries.size() == 0) void'(call_items.pop_front());
            end else if (call_items.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_BITS'({call_items[0].drop_pos, call_items[0].vidx,
                                                 call_items[0].elem, call_items[0].gamma});
                s_axis_tlast  <= call_items[0].last;
                s_axis_tuser  <= call_items[0].op;
                tx_gap = next_gap(tx_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            taken_item = call_items.pop_front();
            expected_entries.push_back(apply_coef_item(TRACK, taken_item));
            in_taken = 1'b1;
        end
    end

    // output side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_hold_done && results_seen >= RX_HOLD_AT) begin
            rx_hold_done = 1'b1;
            rx_hold_left = RX_HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap = next_gap(rx_quiet);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got_entry.pos     = m_axis_tdata[0 +: POS_BITS];
            got_entry.var_idx = m_axis_tdata[POS_BITS +: INDEX_BITS];
            got_entry.coef    = m_axis_tdata[POS_BITS + INDEX_BITS +: COEF_BITS];
            got_entry.norm    = m_axis_tdata[POS_BITS + INDEX_BITS + COEF_BITS +: NORM_BITS];
            got_entry.dropped = m_axis_tuser[0];
            got_entry.status  = m_axis_tuser[1 +: STATUS_BITS];
            got_entry.last    = m_axis_tlast;
            if (expected_entries.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: result with nothing pending: pos %0d var %0d coef %0d",
                             $realtime, got_entry.pos, got_entry.var_idx,
                             $signed(got_entry.coef));
            end else begin
                want_entry = expected_entries.pop_front();
                if (got_entry !== want_entry) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("  expected pos %0d var %0d coef %0d drop %0b norm %0d st %0d last %0b",
                                 want_entry.pos, want_entry.var_idx, $signed(want_entry.coef),
                                 want_entry.dropped, want_entry.norm, want_entry.status,
                                 want_entry.last);
                        $display("  actual   pos %0d var %0d coef %0d drop %0b norm %0d st %0d last %0b",
                                 got_entry.pos, got_entry.var_idx, $signed(got_entry.coef),
                                 got_entry.dropped, got_entry.norm, got_entry.status,
                                 got_entry.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int m = 0; m < 2; m++) begin
            st_count[m] = 0;
            st_rd[m]    = 0;
            st_wr[m]    = 0;
            st_norm[m]  = 0;
            for (int i = 0; i < MAX_ACTIVE; i++) begin
                st_coef[m][i]    = '0;
                st_var[m][i]     = '0;
                st_written[m][i] = 1'b0;
            end
        end
        plan_directed();
        plan_sync();
        plan_full_store();
        plan_sync();
        plan_random();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (call_items.size() != 0 || expected_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_entries.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
